// ===== sv/imhtq_pkg.sv =====
// Package for the indexed min-heap timer queue.
// Holds command and status codes and the fixed field widths of the stream words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imhtq_pkg;
	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 8;
	localparam int FIELD_TIME_W = 32;
	localparam int COUNT_W = 7;
	localparam int IN_W = 80;
	localparam int OUT_W = 64;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_EXPIRE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_HANDLE = 2'd3;
endpackage
`default_nettype wire

// ===== sv/indexed_min_heap_timer_queue_top.sv =====
// Indexed binary min-heap timer queue: top level with the command sequencer.
// Depends on imhtq_pkg and imhtq_ram.
//
// The slave channel (s_tvalid, s_tready, s_tdata) takes one command word at a time.
// The master channel (m_tvalid, m_tready, m_tdata) returns exactly one result word
// per command. After reset the position map is cleared in one pass over all
// HANDLE_COUNT handles, during which s_tready stays low. A command then runs in a
// sequencer that uses at most one read and one write of the slot memory per cycle.
// Insert climbs the heap level by level; remove and update first shift the ancestors
// of the entry down, then remove, update and pop sift down from the root level by
// level; expire pops every due entry in turn. s_tready is high only while the
// sequencer is idle. The result sits in an output register, so a new command is
// taken while the previous result still waits; if the receiver stalls, the next
// result holds the sequencer until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_timer_queue_top #(
	parameter int CAPACITY = 64,
	parameter int HANDLE_COUNT = 256,
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// cmd[2:0], handle[10:3], deadline[42:11], now[74:43], zero fill
	input wire logic [imhtq_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// status[1:0], top_valid[2], top_handle[10:3], top_deadline[42:11],
	// entry_count[49:43], expired_count[56:50], zero fill
	output logic [imhtq_pkg::OUT_W-1:0] m_tdata
);
	import imhtq_pkg::*;

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int PAW = $clog2(HANDLE_COUNT);
	localparam int SW = HANDLE_W + TIME_BITS;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_DISP = 5'd2;
	localparam logic [4:0] S_EXP = 5'd3;
	localparam logic [4:0] S_ROOT = 5'd4;
	localparam logic [4:0] S_RM = 5'd5;
	localparam logic [4:0] S_SH = 5'd6;
	localparam logic [4:0] S_SHW = 5'd7;
	localparam logic [4:0] S_LAST = 5'd8;
	localparam logic [4:0] S_LASTW = 5'd9;
	localparam logic [4:0] S_SD = 5'd10;
	localparam logic [4:0] S_SDL = 5'd11;
	localparam logic [4:0] S_SDR = 5'd12;
	localparam logic [4:0] S_TAIL = 5'd13;
	localparam logic [4:0] S_UP = 5'd14;
	localparam logic [4:0] S_UPC = 5'd15;
	localparam logic [4:0] S_TOP = 5'd16;
	localparam logic [4:0] S_TOPW = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	logic [4:0] state_q;
	logic [PAW-1:0] clr_q;
	logic [CMD_W-1:0] cmd_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [TIME_BITS-1:0] now_q;
	logic [HANDLE_W-1:0] hrm_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] size_q;
	logic [IW-1:0] gone_q;
	logic [STATUS_W-1:0] status_q;
	logic [SW-1:0] x_q;
	logic [SW-1:0] left_q;
	logic [SW-1:0] top_q;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic s_we, s_re, p_we, p_re;
	logic [IW-1:0] s_wa, s_ra;
	logic [SW-1:0] s_wd, slot_rd;
	logic [PAW-1:0] p_wa, p_ra;
	logic [IW-1:0] p_wd, pos_rd;

	logic [HANDLE_W-1:0] rd_h, x_h, best_h;
	logic [TIME_BITS-1:0] rd_d, x_d, left_d, best_d;
	logic [SW-1:0] best;
	logic right_wins;
	logic [IW:0] ch, chr, size_x;
	logic hok, present;

	assign rd_h = slot_rd[HANDLE_W-1:0];
	assign rd_d = slot_rd[SW-1:HANDLE_W];
	assign x_h = x_q[HANDLE_W-1:0];
	assign x_d = x_q[SW-1:HANDLE_W];
	assign left_d = left_q[SW-1:HANDLE_W];
	assign right_wins = rd_d < left_d;
	assign best = right_wins ? slot_rd : left_q;
	assign best_h = best[HANDLE_W-1:0];
	assign best_d = best[SW-1:HANDLE_W];
	assign ch = {cur_q, 1'b0};
	assign chr = ch + (IW+1)'(1);
	assign size_x = {1'b0, size_q};
	assign hok = 32'(hnd_q) < 32'(HANDLE_COUNT);
	assign present = hok && (pos_rd != '0) && (pos_rd <= size_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	imhtq_ram #(.DEPTH(CAPACITY + 1), .WIDTH(SW)) u_slots (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.re(s_re), .raddr(s_ra), .rdata(slot_rd)
	);

	imhtq_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(IW)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
		.re(p_re), .raddr(p_ra), .rdata(pos_rd)
	);

	always_comb begin
		s_we = 1'b0;
		s_wa = '0;
		s_wd = x_q;
		s_re = 1'b0;
		s_ra = '0;
		p_we = 1'b0;
		p_wa = '0;
		p_wd = '0;
		p_re = 1'b0;
		p_ra = PAW'(s_tdata[10:3]);
		unique case (state_q)
			S_CLEAR: begin
				p_we = 1'b1;
				p_wa = clr_q;
			end
			S_IDLE: begin
				p_re = s_tvalid;
			end
			S_DISP: begin
				if (cmd_q == CMD_POP && size_q != '0) begin
					s_re = 1'b1;
					s_ra = IW'(1);
				end
			end
			S_EXP: begin
				if (size_q != '0) begin
					s_re = 1'b1;
					s_ra = IW'(1);
				end
			end
			S_RM: begin
				p_we = 1'b1;
				p_wa = PAW'(hrm_q);
			end
			S_SH: begin
				if (i_q != IW'(1)) begin
					s_re = 1'b1;
					s_ra = i_q >> 1;
				end
			end
			S_SHW: begin
				s_we = 1'b1;
				s_wa = i_q;
				s_wd = slot_rd;
				p_we = 1'b1;
				p_wa = PAW'(rd_h);
				p_wd = i_q;
			end
			S_LAST: begin
				if (size_q > IW'(1)) begin
					s_re = 1'b1;
					s_ra = size_q;
				end
			end
			S_SD: begin
				if (ch > size_x) begin
					s_we = 1'b1;
					s_wa = cur_q;
					p_we = 1'b1;
					p_wa = PAW'(x_h);
					p_wd = cur_q;
				end else begin
					s_re = 1'b1;
					s_ra = IW'(ch);
				end
			end
			S_SDL: begin
				if (chr <= size_x) begin
					s_re = 1'b1;
					s_ra = IW'(chr);
				end else begin
					s_we = 1'b1;
					s_wa = cur_q;
					p_we = 1'b1;
					p_wd = cur_q;
					if (rd_d < x_d) begin
						s_wd = slot_rd;
						p_wa = PAW'(rd_h);
					end else begin
						p_wa = PAW'(x_h);
					end
				end
			end
			S_SDR: begin
				s_we = 1'b1;
				s_wa = cur_q;
				p_we = 1'b1;
				p_wd = cur_q;
				if (best_d < x_d) begin
					s_wd = best;
					p_wa = PAW'(best_h);
				end else begin
					p_wa = PAW'(x_h);
				end
			end
			S_UP: begin
				if (i_q == IW'(1)) begin
					s_we = 1'b1;
					s_wa = i_q;
					p_we = 1'b1;
					p_wa = PAW'(x_h);
					p_wd = i_q;
				end else begin
					s_re = 1'b1;
					s_ra = i_q >> 1;
				end
			end
			S_UPC: begin
				s_we = 1'b1;
				s_wa = i_q;
				p_we = 1'b1;
				p_wd = i_q;
				if (rd_d > x_d) begin
					s_wd = slot_rd;
					p_wa = PAW'(rd_h);
				end else begin
					p_wa = PAW'(x_h);
				end
			end
			S_TOP: begin
				s_re = 1'b1;
				s_ra = IW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			size_q <= '0;
			gone_q <= '0;
			status_q <= STATUS_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PAW'(1);
					if (clr_q == PAW'(HANDLE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tdata[2:0];
						hnd_q <= s_tdata[10:3];
						dl_q <= TIME_BITS'(s_tdata[42:11]);
						now_q <= TIME_BITS'(s_tdata[74:43]);
						status_q <= STATUS_OK;
						gone_q <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_TOP;
					unique case (cmd_q)
						CMD_INSERT: begin
							if (!hok || pos_rd != '0) begin
								status_q <= STATUS_HANDLE;
							end else if (32'(size_q) >= 32'(CAPACITY)) begin
								status_q <= STATUS_FULL;
							end else begin
								size_q <= size_q + IW'(1);
								i_q <= size_q + IW'(1);
								x_q <= {dl_q, hnd_q};
								state_q <= S_UP;
							end
						end
						CMD_REMOVE: begin
							if (!present) begin
								status_q <= STATUS_HANDLE;
							end else begin
								hrm_q <= hnd_q;
								i_q <= pos_rd;
								gone_q <= IW'(1);
								state_q <= S_RM;
							end
						end
						CMD_UPDATE: begin
							if (!present) begin
								status_q <= STATUS_HANDLE;
							end else begin
								i_q <= pos_rd;
								x_q <= {dl_q, hnd_q};
								state_q <= S_SH;
							end
						end
						CMD_POP: begin
							if (size_q == '0) begin
								status_q <= STATUS_EMPTY;
							end else begin
								state_q <= S_ROOT;
							end
						end
						CMD_EXPIRE: begin
							state_q <= S_EXP;
						end
						CMD_PEEK: begin
							if (size_q == '0) begin
								status_q <= STATUS_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
				S_EXP: begin
					state_q <= (size_q == '0) ? S_TOP : S_ROOT;
				end
				S_ROOT: begin
					if (cmd_q == CMD_POP || rd_d <= now_q) begin
						hrm_q <= rd_h;
						i_q <= IW'(1);
						gone_q <= gone_q + IW'(1);
						state_q <= S_RM;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_RM: begin
					state_q <= S_SH;
				end
				S_SH: begin
					if (i_q != IW'(1)) begin
						state_q <= S_SHW;
					end else if (cmd_q == CMD_UPDATE) begin
						cur_q <= IW'(1);
						state_q <= S_SD;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_SHW: begin
					i_q <= i_q >> 1;
					state_q <= S_SH;
				end
				S_LAST: begin
					if (size_q > IW'(1)) begin
						state_q <= S_LASTW;
					end else begin
						size_q <= '0;
						state_q <= S_TAIL;
					end
				end
				S_LASTW: begin
					x_q <= slot_rd;
					size_q <= size_q - IW'(1);
					cur_q <= IW'(1);
					state_q <= S_SD;
				end
				S_SD: begin
					state_q <= (ch > size_x) ? S_TAIL : S_SDL;
				end
				S_SDL: begin
					if (chr <= size_x) begin
						left_q <= slot_rd;
						state_q <= S_SDR;
					end else if (rd_d < x_d) begin
						cur_q <= IW'(ch);
						state_q <= S_SD;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_SDR: begin
					if (best_d < x_d) begin
						cur_q <= right_wins ? IW'(chr) : IW'(ch);
						state_q <= S_SD;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= (cmd_q == CMD_EXPIRE) ? S_EXP : S_TOP;
				end
				S_UP: begin
					state_q <= (i_q == IW'(1)) ? S_TOP : S_UPC;
				end
				S_UPC: begin
					if (rd_d > x_d) begin
						i_q <= i_q >> 1;
						state_q <= S_UP;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					state_q <= S_TOPW;
				end
				S_TOPW: begin
					top_q <= (size_q != '0) ? slot_rd : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {7'b0, COUNT_W'(gone_q), COUNT_W'(size_q),
							FIELD_TIME_W'(top_q[SW-1:HANDLE_W]), top_q[HANDLE_W-1:0],
							(size_q != '0), status_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= 32'(CAPACITY))
		else $error("heap size above capacity");

	a_idle_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(size_q))
		else $error("heap size changed while idle");

	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SD |-> (cur_q != '0 && cur_q <= size_q))
		else $error("sift cursor outside the heap");

	a_top_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2] == 1'b0) == (m_tdata[49:43] == 7'd0)))
		else $error("top valid disagrees with entry count");
endmodule
`default_nettype wire

// ===== sv/imhtq_ram.sv =====
// Single-port-write, single-port-read memory with a registered read.
// Used for the heap slots and the handle position map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module imhtq_ram #(
	parameter int DEPTH = 65,
	parameter int WIDTH = 40
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
